// ===== rtl/act_pkg.sv =====
// Package for the ACL credit handle tracker: event and status codes, slot word,
// controller state type and the command/status bundles between controller and datapath.
// No dependencies.
package act_pkg;

    localparam int FUNC_W   = 3;
    localparam int HANDLE_W = 12;
    localparam int CNT_W    = 16;
    localparam int STAT_W   = 3;

    // event kinds
    localparam logic [FUNC_W-1:0] FN_SUBMIT     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_COMPLETE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DISCONNECT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_BUFSIZE    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RESET      = 3'd4;

    // result codes
    localparam logic [STAT_W-1:0] ST_DONE       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_READY  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_CREDIT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STAT_W-1:0] ST_WIRE_FAIL  = 3'd4;
    localparam logic [STAT_W-1:0] ST_UNKNOWN    = 3'd5;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    outstanding;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_APPLY,
        S_CEIL,
        S_CLAMP,
        S_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan_step;
        logic apply;
        logic ceil;
        logic clamp;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic need_clamp;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/act_if.sv =====
// Valid/ready channel interfaces for the ACL credit tracker: event input and result output.
// Depends on act_pkg for field widths.
interface act_in_if import act_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [HANDLE_W-1:0] handle;
    logic [CNT_W-1:0]    count;
    logic                wire_ok;

    modport source (output valid, func, handle, count, wire_ok, input ready);
    modport sink   (input valid, func, handle, count, wire_ok, output ready);
endinterface

interface act_out_if import act_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  available_credits;
    logic [CNT_W-1:0]  in_flight;

    modport source (output valid, status, available_credits, in_flight, input ready);
    modport sink   (input valid, status, available_credits, in_flight, output ready);
endinterface

// ===== rtl/act_ctrl.sv =====
// Sequencing state machine of the ACL credit tracker.
// Depends on act_pkg (t_state, t_cmd, t_stat).
module act_ctrl
    import act_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = i_stat.need_scan ? S_SCAN : S_APPLY;
            end
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state = i_stat.need_clamp ? S_CEIL : S_RESULT;
            end
            S_CEIL:  n_state = S_CLAMP;
            S_CLAMP: n_state = S_RESULT;
            S_RESULT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: o_cmd.scan_start = i_stat.need_scan;
            S_SCAN:   o_cmd.scan_step  = 1'b1;
            S_APPLY:  o_cmd.apply      = 1'b1;
            S_CEIL:   o_cmd.ceil       = 1'b1;
            S_CLAMP:  o_cmd.clamp      = 1'b1;
            S_RESULT: o_cmd.out_load   = i_stat.out_free;
            default: ;
        endcase
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.scan_start, o_cmd.scan_step, o_cmd.apply,
                  o_cmd.ceil, o_cmd.clamp, o_cmd.out_load}))
        else $error("more than one datapath command at once");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_DECODE))
        else $error("accepted transfer not followed by decode");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_stat.scan_done) |=> (r_state == S_APPLY))
        else $error("finished scan not followed by apply");

endmodule

// ===== rtl/act_dp.sv =====
// Datapath of the ACL credit tracker: item capture, slot table (used bits in flops,
// handle/outstanding in a memory), slot scan, credit update, clamp and result register.
// Depends on act_pkg.
module act_dp
    import act_pkg::*;
#(
    parameter int HANDLE_SLOTS = 8
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [CNT_W-1:0]    i_count,
    input  logic                i_wire_ok,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STAT_W-1:0]   o_status,
    output logic [CNT_W-1:0]    o_available_credits,
    output logic [CNT_W-1:0]    o_in_flight
);

    localparam int IW = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(HANDLE_SLOTS - 1);

    // captured item
    logic [FUNC_W-1:0]   r_func;
    logic [HANDLE_W-1:0] r_handle;
    logic [CNT_W-1:0]    r_count;
    logic                r_wire_ok;

    // block state
    logic                    r_link;
    logic [CNT_W-1:0]        r_credits;
    logic [CNT_W-1:0]        r_buf;
    logic [CNT_W-1:0]        r_in_flight;
    logic [HANDLE_SLOTS-1:0] r_used;
    t_slot                   r_mem [HANDLE_SLOTS];

    // scan
    logic          r_scan_issue;
    logic [IW-1:0] r_scan_addr;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    t_slot         r_rd_data;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [CNT_W-1:0] r_hit_out;
    logic          r_free;
    logic [IW-1:0] r_free_idx;

    logic [CNT_W-1:0]  r_ceil;
    logic [STAT_W-1:0] r_status;

    // result register
    logic              r_out_vld;
    logic [STAT_W-1:0] r_out_status;
    logic [CNT_W-1:0]  r_out_credits;
    logic [CNT_W-1:0]  r_out_in_flight;

    // apply next values
    logic [CNT_W-1:0]        n_credits;
    logic [CNT_W-1:0]        n_buf;
    logic [CNT_W-1:0]        n_in_flight;
    logic [HANDLE_SLOTS-1:0] n_used;
    logic [STAT_W-1:0]       n_status;
    logic                    n_need_clamp;
    logic                    mem_we;
    logic [IW-1:0]           slot_sel;
    t_slot                   mem_wdata;
    logic [CNT_W-1:0]        base_out;
    logic [CNT_W-1:0]        got;

    assign o_stat.need_scan  = ((r_func == FN_SUBMIT) && r_link && (r_credits != '0))
                             || (r_func == FN_COMPLETE) || (r_func == FN_DISCONNECT);
    assign o_stat.scan_done  = !r_scan_issue && !r_rd_vld;
    // decided in the apply cycle from the event kind and the scan outcome
    assign o_stat.need_clamp = n_need_clamp;
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

    assign slot_sel = r_hit ? r_hit_idx : r_free_idx;
    assign base_out = r_hit ? r_hit_out : '0;
    assign got      = (r_hit_out >= r_count) ? r_count : r_hit_out;

    always_comb begin
        n_credits    = r_credits;
        n_buf        = r_buf;
        n_in_flight  = r_in_flight;
        n_used       = r_used;
        n_status     = ST_DONE;
        n_need_clamp = 1'b0;
        mem_we       = 1'b0;
        mem_wdata    = '{handle: r_handle, outstanding: base_out};
        unique case (r_func)
            FN_SUBMIT: begin
                if (!r_link) begin
                    n_status = ST_NOT_READY;
                end else if (r_credits == '0) begin
                    n_status = ST_NO_CREDIT;
                end else if (!r_hit && !r_free) begin
                    n_status = ST_TABLE_FULL;
                end else begin
                    // slot stays claimed even if the wire refuses
                    n_used[slot_sel] = 1'b1;
                    mem_we           = 1'b1;
                    mem_wdata.outstanding = base_out + {{(CNT_W-1){1'b0}}, r_wire_ok};
                    if (!r_wire_ok) begin
                        n_status = ST_WIRE_FAIL;
                    end else begin
                        n_credits   = r_credits - CNT_W'(1);
                        n_in_flight = r_in_flight + CNT_W'(1);
                    end
                end
            end
            FN_COMPLETE: begin
                if (!r_hit) begin
                    n_status = ST_UNKNOWN;
                end else begin
                    mem_we                = 1'b1;
                    mem_wdata.outstanding = r_hit_out - got;
                    n_credits             = r_credits + got;
                    n_in_flight           = r_in_flight - got;
                    n_need_clamp          = 1'b1;
                end
            end
            FN_DISCONNECT: begin
                if (!r_hit) begin
                    n_status = ST_UNKNOWN;
                end else begin
                    n_used[r_hit_idx] = 1'b0;
                    n_credits         = r_credits + r_hit_out;
                    n_in_flight       = r_in_flight - r_hit_out;
                    n_need_clamp      = 1'b1;
                end
            end
            FN_BUFSIZE: begin
                if (r_buf == '0) begin
                    n_used      = '0;
                    n_in_flight = '0;
                    n_credits   = r_count;
                end
                n_buf        = r_count;
                n_need_clamp = 1'b1;
            end
            FN_RESET: begin
                n_used      = '0;
                n_in_flight = '0;
                n_credits   = r_buf;
            end
            default: ;
        endcase
    end

    // item capture, payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= i_func;
            r_handle  <= i_handle;
            r_count   <= i_count;
            r_wire_ok <= i_wire_ok;
        end
    end

    // slot memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && mem_we) begin
            r_mem[slot_sel] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_scan_addr];
    end

    // scan payload, ceiling and result payload
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_scan_addr;
        if (i_cmd.scan_step && r_rd_vld) begin
            if (r_used[r_rd_idx] && !r_hit && (r_rd_data.handle == r_handle)) begin
                r_hit_idx <= r_rd_idx;
                r_hit_out <= r_rd_data.outstanding;
            end
            if (!r_used[r_rd_idx] && !r_free) begin
                r_free_idx <= r_rd_idx;
            end
        end
        if (i_cmd.ceil) begin
            r_ceil <= (r_buf > r_in_flight) ? (r_buf - r_in_flight) : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status    <= r_status;
            r_out_credits   <= r_credits;
            r_out_in_flight <= r_in_flight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link       <= 1'b0;
            r_credits    <= '0;
            r_buf        <= '0;
            r_in_flight  <= '0;
            r_used       <= '0;
            r_scan_issue <= 1'b0;
            r_scan_addr  <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free       <= 1'b0;
            r_status     <= ST_DONE;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_link <= i_cfg_wdata;
            end
            if (i_cmd.scan_start) begin
                r_scan_issue <= 1'b1;
                r_scan_addr  <= '0;
                r_rd_vld     <= 1'b0;
                r_hit        <= 1'b0;
                r_free       <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_vld <= r_scan_issue;
                if (r_scan_issue) begin
                    if (r_scan_addr == LAST_IDX) begin
                        r_scan_issue <= 1'b0;
                    end else begin
                        r_scan_addr <= r_scan_addr + IW'(1);
                    end
                end
                if (r_rd_vld) begin
                    if (r_used[r_rd_idx] && (r_rd_data.handle == r_handle)) begin
                        r_hit <= 1'b1;
                    end
                    if (!r_used[r_rd_idx]) begin
                        r_free <= 1'b1;
                    end
                end
            end
            if (i_cmd.apply) begin
                r_credits    <= n_credits;
                r_buf        <= n_buf;
                r_in_flight  <= n_in_flight;
                r_used       <= n_used;
                r_status     <= n_status;
            end
            if (i_cmd.clamp && (r_credits > r_ceil)) begin
                r_credits <= r_ceil;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_status            = r_out_status;
    assign o_available_credits = r_out_credits;
    assign o_in_flight         = r_out_in_flight;

    a_clamp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clamp |=> (r_credits <= r_buf))
        else $error("credits above buffer total after clamp");

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && (r_func == FN_RESET)) |=> ((r_used == '0) && (r_in_flight == '0)))
        else $error("reset event left slots in use");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_issue |-> (r_scan_addr <= LAST_IDX))
        else $error("scan address beyond slot table");

endmodule

// ===== rtl/acl_credit_handle_tracker.sv =====
// Top level of the ACL credit handle tracker: joins controller and datapath to the channels.
// Depends on act_pkg, act_if (act_in_if, act_out_if), act_ctrl and act_dp.
//
//  channel    dir  handshake      payload
//  i_item     in   valid/ready    func[2:0] handle[11:0] count[15:0] wire_ok
//  o_result   out  valid/ready    status[2:0] available_credits[15:0] in_flight[15:0]
//  i_cfg_*    in   write enable   link_ready (one bit, no address)
//
// One item at a time. Submits that pass the link and credit checks, completions and
// disconnections scan the slot table, one slot read per cycle from the slot memory.
// Each item passes decode, the optional scan, apply, the optional ceiling and clamp
// steps and the result step; the clamp follows buffer-size reports and completions
// or disconnections that find their handle. The next item is taken back in idle.
// Reset is synchronous, active low; it empties the table through the per-slot used
// flops at once, so there is no clearing pass.
// A new item is taken while an earlier result still sits in the output register; the
// result of that item waits in its last state until the register is free.
module acl_credit_handle_tracker
    import act_pkg::*;
#(
    parameter int HANDLE_SLOTS = 8
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    act_in_if.sink    i_item,
    act_out_if.source o_result,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    t_cmd  w_cmd;   // controller commands
    t_stat w_stat;  // datapath status back to controller
    logic  w_in_ready;

    assign i_item.ready = w_in_ready;

    act_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    act_dp #(
        .HANDLE_SLOTS (HANDLE_SLOTS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_func              (i_item.func),
        .i_handle            (i_item.handle),
        .i_count             (i_item.count),
        .i_wire_ok           (i_item.wire_ok),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_out_ready         (o_result.ready),
        .o_out_valid         (o_result.valid),
        .o_status            (o_result.status),
        .o_available_credits (o_result.available_credits),
        .o_in_flight         (o_result.in_flight)
    );

endmodule

// ===== verif/acl_credit_handle_tracker_tb.sv =====
`timescale 1ns / 100ps
// Testbench for acl_credit_handle_tracker. A directed event list and then random event streams
// run, and a scoreboard predicts each result's status, credits and packets in flight.
// Depends on act_pkg and the act_in_if / act_out_if interfaces from the RTL.
module acl_credit_handle_tracker_tb;
    import act_pkg::*;

    localparam int SLOTS       = 8;
    localparam int CLK_HALF    = 5;
    localparam int POOL_N      = 10;      // more handles than slots, so the table fills up
    localparam int HOLD_CYCLES = 200;     // long receiver back-off, fills the block
    localparam int IDLE_LIMIT  = 2000;    // cycles without any transfer before giving up
    localparam int TAIL_CYCLES = 3 * (SLOTS + 9);
    localparam int PHASES      = 7;
    localparam int ITEMS_UP    = 200;     // random items per phase with the link up
    localparam int ITEMS_DOWN  = 60;      // and with the link down (mostly refusals)
    // link_ready per random phase, bit n for phase n
    localparam logic [PHASES-1:0] LINK_PLAN = 7'b1011011;
    localparam int FUNC_MAX    = (1 << FUNC_W) - 1;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    count;
        logic                wire_ok;
    } t_event;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  credits;
        logic [CNT_W-1:0]  in_flight;
    } t_result;

    // Credit tracker prediction plus the queue of results still owed by the block
    class credit_scoreboard;
        bit                  link_up;
        logic [CNT_W-1:0]    credits;
        logic [CNT_W-1:0]    buf_total;
        bit                  slot_used[SLOTS];
        logic [HANDLE_W-1:0] slot_hnd[SLOTS];
        logic [CNT_W-1:0]    slot_outst[SLOTS];
        t_result             expected_results[$];
        int                  errors;

        function new();
            link_up   = 1'b0;
            credits   = '0;
            buf_total = '0;
            errors    = 0;
            clear_slots();
        endfunction

        function void clear_slots();
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i]  = 1'b0;
                slot_hnd[i]   = '0;
                slot_outst[i] = '0;
            end
        endfunction

        // 16-bit sum, wraps like the hardware counter
        function logic [CNT_W-1:0] in_flight_sum();
            logic [CNT_W-1:0] s;
            s = '0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i]) s = s + slot_outst[i];
            return s;
        endfunction

        function void clamp_credits();
            logic [CNT_W-1:0] fl;
            logic [CNT_W-1:0] ceiling;
            if (buf_total == '0) begin
                credits = '0;
            end else begin
                fl      = in_flight_sum();
                ceiling = (buf_total > fl) ? buf_total - fl : '0;
                if (credits > ceiling) credits = ceiling;
            end
        endfunction

        function int find_slot(logic [HANDLE_W-1:0] h);
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_hnd[i] == h) return i;
            return -1;
        endfunction

        function t_result step_tracker(t_event ev);
            t_result          r;
            int               s;
            logic [CNT_W-1:0] got;
            r.status = ST_DONE;
            case (ev.func)
                FN_SUBMIT: begin
                    if (!link_up) begin
                        r.status = ST_NOT_READY;
                    end else if (credits == '0) begin
                        r.status = ST_NO_CREDIT;
                    end else begin
                        // reuse a matching slot, else claim the lowest free one
                        s = find_slot(ev.handle);
                        if (s < 0) begin
                            for (int i = SLOTS - 1; i >= 0; i--)
                                if (!slot_used[i]) s = i;
                            if (s >= 0) begin
                                slot_used[s]  = 1'b1;
                                slot_hnd[s]   = ev.handle;
                                slot_outst[s] = '0;
                            end
                        end
                        if (s < 0) begin
                            r.status = ST_TABLE_FULL;
                        end else if (!ev.wire_ok) begin
                            r.status = ST_WIRE_FAIL;   // slot stays claimed
                        end else begin
                            credits       = credits - 1'b1;
                            slot_outst[s] = slot_outst[s] + 1'b1;
                        end
                    end
                end
                FN_COMPLETE: begin
                    s = find_slot(ev.handle);
                    if (s < 0) begin
                        r.status = ST_UNKNOWN;
                    end else begin
                        got           = (slot_outst[s] >= ev.count) ? ev.count : slot_outst[s];
                        slot_outst[s] = slot_outst[s] - got;
                        credits       = credits + got;
                        clamp_credits();
                    end
                end
                FN_DISCONNECT: begin
                    s = find_slot(ev.handle);
                    if (s < 0) begin
                        r.status = ST_UNKNOWN;
                    end else begin
                        credits       = credits + slot_outst[s];
                        slot_outst[s] = '0;
                        slot_used[s]  = 1'b0;
                        clamp_credits();
                    end
                end
                FN_BUFSIZE: begin
                    if (buf_total == '0) begin
                        clear_slots();
                        credits = ev.count;
                    end
                    buf_total = ev.count;
                    clamp_credits();
                end
                FN_RESET: begin
                    clear_slots();
                    credits = buf_total;
                end
                default: ;
            endcase
            r.credits   = credits;
            r.in_flight = in_flight_sum();
            return r;
        endfunction

        function void note_transfer(t_event ev);
            expected_results.push_back(step_tracker(ev));
        endfunction

        function void compare_field(string field, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got status %0d credits %0d in_flight %0d",
                         $time, got.status, got.credits, got.in_flight);
            end else begin
                want = expected_results.pop_front();
                compare_field("status", CNT_W'(want.status), CNT_W'(got.status));
                compare_field("available_credits", want.credits, got.credits);
                compare_field("in_flight", want.in_flight, got.in_flight);
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we;
    logic i_cfg_wdata;

    act_in_if  item_ch();
    act_out_if result_ch();

    credit_scoreboard    tracker_sb;
    logic [HANDLE_W-1:0] handle_pool[POOL_N];
    bit                  no_idle      = 1'b0;  // both sides stream back to back
    int                  hold_request = 0;     // one-off receiver back-off, in cycles
    int                  quiet_cycles = 0;

    acl_credit_handle_tracker #(
        .HANDLE_SLOTS (SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Watchdog: too long without a transfer on either channel means the block has hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_event mk_event(logic [FUNC_W-1:0] f, logic [HANDLE_W-1:0] h,
                                        logic [CNT_W-1:0] c, logic w);
        t_event ev;
        ev.func    = f;
        ev.handle  = h;
        ev.count   = c;
        ev.wire_ok = w;
        return ev;
    endfunction

    // Fresh handle set per phase; the extremes go in about half the time
    function automatic void fill_pool();
        for (int i = 0; i < POOL_N; i++) handle_pool[i] = HANDLE_W'($urandom());
        if ($urandom_range(0, 1)) begin
            handle_pool[0] = '0;
            handle_pool[1] = '1;
        end
    endfunction

    // Mostly submits and returns on pooled handles, so slots get reused and the table
    // fills; unused fields carry random bits anyway.
    function automatic t_event random_event();
        t_event ev;
        int     pick;
        pick       = $urandom_range(0, 99);
        ev.handle  = ($urandom_range(0, 19) == 0) ? HANDLE_W'($urandom())
                                                  : handle_pool[$urandom_range(0, POOL_N - 1)];
        ev.count   = CNT_W'($urandom());
        ev.wire_ok = ($urandom_range(0, 9) != 0);
        if (pick < 50) begin
            ev.func = FN_SUBMIT;
        end else if (pick < 70) begin
            ev.func = FN_COMPLETE;
            if ($urandom_range(0, 7) != 0) ev.count = CNT_W'($urandom_range(0, 4));
        end else if (pick < 82) begin
            ev.func = FN_DISCONNECT;
        end else if (pick < 90) begin
            ev.func = FN_BUFSIZE;
            case ($urandom_range(0, 7))
                0:       ev.count = '0;
                1:       ;                   // keep the full-range count
                default: ev.count = CNT_W'($urandom_range(1, 40));
            endcase
        end else if (pick < 95) begin
            ev.func = FN_RESET;
        end else begin
            ev.func = FUNC_W'($urandom_range(int'(FN_RESET) + 1, FUNC_MAX));
        end
        return ev;
    endfunction

    // Offer one event, after an optional gap, and hold it until the transfer.
    // valid is left high on return so back-to-back items never drop it.
    task automatic send_event(input t_event ev);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.func    <= ev.func;
        item_ch.handle  <= ev.handle;
        item_ch.count   <= ev.count;
        item_ch.wire_ok <= ev.wire_ok;
        do @(posedge i_clk); while (!(item_ch.valid && item_ch.ready));
        tracker_sb.note_transfer(ev);
    endtask

    // Result side: random back-off per item, plus any long hold asked for by the sender
    task automatic collect_results();
        int      gap;
        t_result got;
        forever begin
            gap          = (no_idle ? 0 : $urandom_range(0, 5)) + hold_request;
            hold_request = 0;
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_ch.valid && result_ch.ready));
            got.status    = result_ch.status;
            got.credits   = result_ch.available_credits;
            got.in_flight = result_ch.in_flight;
            tracker_sb.check_result(got);
        end
    endtask

    // Stop offering and wait for every owed result
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker_sb.expected_results.size() != 0);
    endtask

    // link_ready only changes with the block idle
    task automatic write_link(input logic v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker_sb.link_up = v;
    endtask

    initial begin
        item_ch.valid   <= 1'b0;
        item_ch.func    <= FN_SUBMIT;
        item_ch.handle  <= '0;
        item_ch.count   <= '0;
        item_ch.wire_ok <= 1'b0;
        result_ch.ready <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 1'b0;
        tracker_sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            collect_results();
        join_none

        // Directed: link down, so submits are refused even once credit exists
        write_link(1'b0);
        send_event(mk_event(FN_SUBMIT, 12'h123, '0, 1'b1));
        send_event(mk_event(FN_BUFSIZE, 12'h000, 16'd4, 1'b0));   // first report sets credits
        send_event(mk_event(FN_SUBMIT, 12'h123, '0, 1'b1));

        write_link(1'b1);
        send_event(mk_event(FN_SUBMIT, 12'h000, '0, 1'b1));
        send_event(mk_event(FN_SUBMIT, 12'hFFF, '1, 1'b0));       // wire fails, slot kept
        send_event(mk_event(FN_SUBMIT, 12'hFFF, '0, 1'b1));
        send_event(mk_event(FN_COMPLETE, 12'h555, 16'd1, 1'b0));  // handle not in table
        send_event(mk_event(FN_COMPLETE, 12'h000, '0, 1'b0));     // zero count
        send_event(mk_event(FN_COMPLETE, 12'h000, '1, 1'b0));     // limited to outstanding
        send_event(mk_event(FN_DISCONNECT, 12'hABC, '0, 1'b0));   // handle not in table
        send_event(mk_event(FN_DISCONNECT, 12'hFFF, '0, 1'b0));
        send_event(mk_event(FN_BUFSIZE, 12'h000, '1, 1'b0));      // later report keeps credits
        send_event(mk_event(FN_RESET, 12'h000, '0, 1'b0));        // credits back to total
        for (int h = 1; h <= SLOTS; h++)
            send_event(mk_event(FN_SUBMIT, HANDLE_W'(h), '0, 1'b1));
        send_event(mk_event(FN_SUBMIT, HANDLE_W'(SLOTS + 1), '0, 1'b1));  // table full
        send_event(mk_event(FN_BUFSIZE, 12'h000, 16'd2, 1'b0));   // clamp below in-flight
        send_event(mk_event(FN_SUBMIT, 12'h001, '0, 1'b1));       // no credit
        send_event(mk_event(FN_DISCONNECT, 12'h001, '0, 1'b0));
        send_event(mk_event(FN_BUFSIZE, 12'h000, '0, 1'b0));      // zero total, credits zero
        for (int f = int'(FN_RESET) + 1; f <= FUNC_MAX; f++)
            send_event(mk_event(FUNC_W'(f), 12'h7A5, 16'hA5A5, 1'b1));  // undefined kinds

        // Random phases; each change of link_ready waits for the block to drain
        for (int ph = 0; ph < PHASES; ph++) begin
            write_link(LINK_PLAN[ph]);
            fill_pool();
            no_idle = (ph == 3);
            for (int n = 0; n < (LINK_PLAN[ph] ? ITEMS_UP : ITEMS_DOWN); n++) begin
                // back-pressure burst: receiver stalls while items keep being offered
                if (ph == 1 && n == 60) hold_request = HOLD_CYCLES;
                send_event(random_event());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker_sb.errors == 0 && tracker_sb.expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/act_pkg.sv
rtl/act_if.sv
rtl/act_ctrl.sv
rtl/act_dp.sv
rtl/acl_credit_handle_tracker.sv
verif/acl_credit_handle_tracker_tb.sv
